// ===== hw/rtl/hsv_to_rgb_unit_assert.svh =====
// Assertion macros for the HSV to RGB conversion block.
// Uses the clk and rst_n signals of the including module; no other dependencies.
`ifndef HSV_TO_RGB_UNIT_ASSERT_SVH
`define HSV_TO_RGB_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define HSV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsv_to_rgb_unit: same-cycle check failed");

// next-cycle implication
`define HSV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsv_to_rgb_unit: next-cycle check failed");

`else

`define HSV_ASSERT_NOW(lbl, ante, cons)
`define HSV_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/hsv_pkg.sv =====
// Shared types and constants for the HSV to RGB conversion pipeline.
// No dependencies.
package hsv_pkg;

  localparam int HUE_W = 15;
  localparam int Q_W   = 9;
  localparam int W_W   = 12;   // x weight, 0..3840
  localparam int VS_W  = 17;   // v*s and offset, scale 2^16
  localparam int VSW_W = 28;   // v*s*w and the x numerator
  localparam int CH_W  = 8;

  localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_DOUBLE = 15'd7680;
  localparam logic [Q_W-1:0]   Q_ONE      = 9'd256;

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,   // (C,X,0)
    SEC_YG = 3'd1,   // (X,C,0)
    SEC_GC = 3'd2,   // (0,C,X)
    SEC_CB = 3'd3,   // (0,X,C)
    SEC_BM = 3'd4,   // (X,0,C)
    SEC_MR = 3'd5    // (C,0,X)
  } sector_t;

  // after hue reduction and clamping
  typedef struct packed {
    sector_t          sector;
    logic [W_W-1:0]   weight;
    logic [Q_W-1:0]   sat;
    logic [Q_W-1:0]   val;
  } hsv_s1_t;

  // after chroma products
  typedef struct packed {
    sector_t           sector;
    logic [CH_W-1:0]   comp_c;
    logic [VS_W-1:0]   off;
    logic [VSW_W-1:0]  vsw;
  } hsv_s3_t;

endpackage

// ===== hw/rtl/hsv_sector.sv =====
// Stage 1: clamps saturation/value, finds the hue sector and the x weight.
// Depends on hsv_pkg.
module hsv_sector (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [hsv_pkg::HUE_W-1:0] hue,
  input  logic [hsv_pkg::Q_W-1:0]   sat,
  input  logic [hsv_pkg::Q_W-1:0]   val,
  output logic                      out_valid,
  input  logic                      out_ready,
  output hsv_pkg::hsv_s1_t          out_data
);

  localparam logic [hsv_pkg::HUE_W-1:0] HUE_X2 = hsv_pkg::HUE_W'(2 * hsv_pkg::HUE_DOUBLE);
  localparam logic [hsv_pkg::HUE_W-1:0] HUE_X3 = hsv_pkg::HUE_W'(3 * hsv_pkg::HUE_DOUBLE);
  localparam logic [hsv_pkg::HUE_W-1:0] HUE_X4 = hsv_pkg::HUE_W'(4 * hsv_pkg::HUE_DOUBLE);

  logic                      valid_r;
  hsv_pkg::hsv_s1_t          data_r;
  hsv_pkg::hsv_s1_t          data_nxt;
  logic [hsv_pkg::HUE_W-1:0] t_mod;
  logic [hsv_pkg::HUE_W-1:0] w_full;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    // hue mod 7680, hue < 2^15 so at most four periods
    if (hue >= HUE_X4)                   t_mod = hue - HUE_X4;
    else if (hue >= HUE_X3)              t_mod = hue - HUE_X3;
    else if (hue >= HUE_X2)              t_mod = hue - HUE_X2;
    else if (hue >= hsv_pkg::HUE_DOUBLE) t_mod = hue - hsv_pkg::HUE_DOUBLE;
    else                                 t_mod = hue;

    w_full = (t_mod >= hsv_pkg::HUE_SECTOR) ? (hsv_pkg::HUE_DOUBLE - t_mod) : t_mod;
    data_nxt.weight = w_full[hsv_pkg::W_W-1:0];

    // hue beyond 360 degrees stays in the last sector
    if (hue >= 5 * hsv_pkg::HUE_SECTOR)      data_nxt.sector = hsv_pkg::SEC_MR;
    else if (hue >= 4 * hsv_pkg::HUE_SECTOR) data_nxt.sector = hsv_pkg::SEC_BM;
    else if (hue >= 3 * hsv_pkg::HUE_SECTOR) data_nxt.sector = hsv_pkg::SEC_CB;
    else if (hue >= 2 * hsv_pkg::HUE_SECTOR) data_nxt.sector = hsv_pkg::SEC_GC;
    else if (hue >= hsv_pkg::HUE_SECTOR)     data_nxt.sector = hsv_pkg::SEC_YG;
    else                                     data_nxt.sector = hsv_pkg::SEC_RY;

    data_nxt.sat = (sat > hsv_pkg::Q_ONE) ? hsv_pkg::Q_ONE : sat;
    data_nxt.val = (val > hsv_pkg::Q_ONE) ? hsv_pkg::Q_ONE : val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== hw/rtl/hsv_chroma.sv =====
// Stages 2 and 3: chroma v*s, full-scale C channel, offset and v*s*w product.
// Depends on hsv_pkg.
module hsv_chroma (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hsv_pkg::hsv_s1_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output hsv_pkg::hsv_s3_t out_data
);

  typedef struct packed {
    hsv_pkg::sector_t          sector;
    logic [hsv_pkg::W_W-1:0]   weight;
    logic [hsv_pkg::Q_W-1:0]   val;
    logic [hsv_pkg::CH_W-1:0]  comp_c;
    logic [hsv_pkg::VS_W-1:0]  vs;
  } s2_t;

  logic                           s2_valid_r;
  logic                           s3_valid_r;
  s2_t                            s2_r;
  s2_t                            s2_nxt;
  hsv_pkg::hsv_s3_t               s3_r;
  hsv_pkg::hsv_s3_t               s3_nxt;
  logic                           s2_ready;
  logic                           s3_ready;
  logic [2*hsv_pkg::Q_W-1:0]      vs_full;
  logic [hsv_pkg::VS_W-1:0]       v255;
  logic [hsv_pkg::VS_W+hsv_pkg::W_W-1:0] vsw_full;

  assign s3_ready = !s3_valid_r || out_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign in_ready = s2_ready;

  always_comb begin
    vs_full       = in_data.sat * in_data.val;
    // 255*v = 256*v - v
    v255          = {in_data.val, 8'd0} - {8'd0, in_data.val};
    s2_nxt.sector = in_data.sector;
    s2_nxt.weight = in_data.weight;
    s2_nxt.val    = in_data.val;
    s2_nxt.comp_c = v255[15:8];
    s2_nxt.vs     = vs_full[hsv_pkg::VS_W-1:0];
  end

  always_comb begin
    vsw_full      = s2_r.vs * s2_r.weight;
    s3_nxt.sector = s2_r.sector;
    s3_nxt.comp_c = s2_r.comp_c;
    s3_nxt.off    = {s2_r.val, 8'd0} - s2_r.vs;
    s3_nxt.vsw    = vsw_full[hsv_pkg::VSW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s2_ready) s2_valid_r <= in_valid;
      if (s3_ready) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && in_valid) s2_r <= s2_nxt;
    if (s3_ready && s2_valid_r) s3_r <= s3_nxt;
  end

  assign out_valid = s3_valid_r;
  assign out_data  = s3_r;

endmodule

// ===== hw/rtl/hsv_blend.sv =====
// Stages 4 and 5: x numerator, offset channel, x channel and sector routing
// into the output register. Depends on hsv_pkg.
module hsv_blend (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  hsv_pkg::hsv_s3_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [hsv_pkg::CH_W-1:0]  red,
  output logic [hsv_pkg::CH_W-1:0]  green,
  output logic [hsv_pkg::CH_W-1:0]  blue
);

  typedef struct packed {
    hsv_pkg::sector_t           sector;
    logic [hsv_pkg::CH_W-1:0]   comp_c;
    logic [hsv_pkg::CH_W-1:0]   comp_z;
    logic [hsv_pkg::VSW_W-1:0]  num;
  } s4_t;

  logic                          s4_valid_r;
  logic                          o_valid_r;
  s4_t                           s4_r;
  s4_t                           s4_nxt;
  logic                          s4_ready;
  logic                          o_ready;
  logic [hsv_pkg::VSW_W:0]       num_full;
  logic [24:0]                   off255;
  logic [hsv_pkg::VSW_W+4:0]     num17;
  logic [hsv_pkg::CH_W-1:0]      comp_x;
  logic [hsv_pkg::CH_W-1:0]      red_r, green_r, blue_r;
  logic [hsv_pkg::CH_W-1:0]      red_nxt, green_nxt, blue_nxt;

  assign o_ready  = !o_valid_r || out_ready;
  assign s4_ready = !s4_valid_r || o_ready;
  assign in_ready = s4_ready;

  always_comb begin
    // off*3840 = off*4096 - off*256
    num_full = {1'b0, in_data.vsw} + {in_data.off, 12'd0}
             - {4'd0, in_data.off, 8'd0};
    off255   = {in_data.off, 8'd0} - {8'd0, in_data.off};
    s4_nxt.sector = in_data.sector;
    s4_nxt.comp_c = in_data.comp_c;
    s4_nxt.comp_z = off255[23:16];
    s4_nxt.num    = num_full[hsv_pkg::VSW_W-1:0];
  end

  always_comb begin
    // 255/(65536*3840) = 17/2^24
    num17  = {1'b0, s4_r.num, 4'd0} + {5'd0, s4_r.num};
    comp_x = num17[31:24];
    case (s4_r.sector)
      hsv_pkg::SEC_RY: begin red_nxt = s4_r.comp_c; green_nxt = comp_x;      blue_nxt = s4_r.comp_z; end
      hsv_pkg::SEC_YG: begin red_nxt = comp_x;      green_nxt = s4_r.comp_c; blue_nxt = s4_r.comp_z; end
      hsv_pkg::SEC_GC: begin red_nxt = s4_r.comp_z; green_nxt = s4_r.comp_c; blue_nxt = comp_x;      end
      hsv_pkg::SEC_CB: begin red_nxt = s4_r.comp_z; green_nxt = comp_x;      blue_nxt = s4_r.comp_c; end
      hsv_pkg::SEC_BM: begin red_nxt = comp_x;      green_nxt = s4_r.comp_z; blue_nxt = s4_r.comp_c; end
      default:         begin red_nxt = s4_r.comp_c; green_nxt = s4_r.comp_z; blue_nxt = comp_x;      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (s4_ready) s4_valid_r <= in_valid;
      if (o_ready)  o_valid_r  <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && in_valid) s4_r <= s4_nxt;
    if (o_ready && s4_valid_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

endmodule

// ===== hw/rtl/hsv_to_rgb_unit.sv =====
// Top level of the HSV to RGB conversion block: five-stage pipeline.
// Depends on hsv_pkg, hsv_sector, hsv_chroma, hsv_blend and the assert header.
//
//   channel  direction  tdata fields (low bit up)                     width
//   in_      slave      hue[14:0] saturation[23:15] brightness[32:24]  40
//   out_     master     red[7:0] green[15:8] blue[23:16]               24
//
// One pixel enters per cycle while out_tready does not stall the pipeline; each pixel
// passes five register stages (sector, chroma, x-product, numerator, output register)
// before out_tvalid rises for it.
// Reset (rst_n low, synchronous) empties the pipeline; there is no other state.
// A stall on out_tready holds every occupied stage; empty stages keep filling,
// so in_tready drops only once all five stages hold a pixel.
`include "hsv_to_rgb_unit_assert.svh"

module hsv_to_rgb_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // hue[14:0], saturation[23:15], brightness[32:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  logic             s1_valid;
  logic             s1_ready;
  hsv_pkg::hsv_s1_t s1_data;
  logic             s3_valid;
  logic             s3_ready;
  hsv_pkg::hsv_s3_t s3_data;
  logic [hsv_pkg::CH_W-1:0] red;
  logic [hsv_pkg::CH_W-1:0] green;
  logic [hsv_pkg::CH_W-1:0] blue;

  hsv_sector u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .hue       (in_tdata[14:0]),
    .sat       (in_tdata[23:15]),
    .val       (in_tdata[32:24]),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  hsv_chroma u_chroma (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_data  (s3_data)
  );

  hsv_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_data   (s3_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  assign out_tdata = {blue, green, red};

  // an open output lets every stage move
  `HSV_ASSERT_NOW(a_ready_chain, out_tready, in_tready)
  // backpressure at the input only when the output holds a stalled pixel
  `HSV_ASSERT_NOW(a_full_means_held, !in_tready, out_tvalid && !out_tready)
  // a stalled transaction between stages keeps its data
  `HSV_ASSERT_NEXT(a_mid_hold, s1_valid && !s1_ready, s1_valid && $stable(s1_data))

endmodule

// ===== verif/hsv_to_rgb_unit_checker.sv =====
// Checker for hsv_to_rgb_unit: predicts each RGB pixel from the accepted HSV
// transaction and compares it with the result stream in order. Depends on hsv_pkg.
module hsv_to_rgb_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  output int          mismatches,
  output int          outstanding,
  output int          checked
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  rgb_t pending_pixels[$];

  function automatic rgb_t hsv_pixel_to_rgb(logic [14:0] hue, logic [8:0] sat_in,
                                            logic [8:0] val_in);
    longint unsigned s, v, t, w, vs, full, off, c, x, z, idx;
    hsv_pkg::sector_t sec;
    rgb_t px;
    // saturation and value clamp at 1.0
    s = (sat_in > hsv_pkg::Q_ONE) ? hsv_pkg::Q_ONE : sat_in;
    v = (val_in > hsv_pkg::Q_ONE) ? hsv_pkg::Q_ONE : val_in;
    t = hue % hsv_pkg::HUE_DOUBLE;
    w = (t >= hsv_pkg::HUE_SECTOR) ? (hsv_pkg::HUE_DOUBLE - t) : t;
    vs = v * s;
    full = v * hsv_pkg::Q_ONE;
    off = full - vs;
    c = (255 * full) >> 16;
    z = (255 * off) >> 16;
    x = (255 * (vs * w + off * hsv_pkg::HUE_SECTOR))
        / (longint'(65536) * hsv_pkg::HUE_SECTOR);
    // hue past 360 degrees stays in the last sector
    idx = hue / hsv_pkg::HUE_SECTOR;
    if (idx > 5) idx = 5;
    sec = hsv_pkg::sector_t'(idx[2:0]);
    case (sec)
      hsv_pkg::SEC_RY: px = '{c[7:0], x[7:0], z[7:0]};
      hsv_pkg::SEC_YG: px = '{x[7:0], c[7:0], z[7:0]};
      hsv_pkg::SEC_GC: px = '{z[7:0], c[7:0], x[7:0]};
      hsv_pkg::SEC_CB: px = '{z[7:0], x[7:0], c[7:0]};
      hsv_pkg::SEC_BM: px = '{x[7:0], z[7:0], c[7:0]};
      default: px = '{c[7:0], z[7:0], x[7:0]};
    endcase
    return px;
  endfunction

  initial begin
    mismatches = 0;
    checked = 0;
  end

  assign outstanding = pending_pixels.size();

  always @(posedge clk) begin
    rgb_t want, got;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        pending_pixels.push_back(hsv_pixel_to_rgb(in_tdata[14:0], in_tdata[23:15],
                                                  in_tdata[32:24]));
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[7:0], out_tdata[15:8], out_tdata[23:16]};
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time,
                   got.red, got.green, got.blue);
          mismatches++;
        end else begin
          want = pending_pixels.pop_front();
          checked++;
          if (got.red !== want.red) begin
            $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
            mismatches++;
          end
          if (got.green !== want.green) begin
            $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
            mismatches++;
          end
          if (got.blue !== want.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

// ===== verif/hsv_to_rgb_unit_test.sv =====
// Top of the hsv_to_rgb_unit testbench: clock, reset, HSV stimulus, result
// back-pressure and the verdict. Depends on hsv_pkg, hsv_to_rgb_unit and hsv_to_rgb_unit_checker.
module hsv_to_rgb_unit_test;

  localparam int RANDOM_PIXELS = 650;
  localparam int CYCLE_LIMIT   = 100000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        steady = 1'b0;   // no idling on either side while set
  int          mismatches, outstanding, checked;
  int          out_of_range;

  hsv_to_rgb_unit uut (.*);

  hsv_to_rgb_unit_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .mismatches, .outstanding, .checked
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d pixels still pending", CYCLE_LIMIT, outstanding);
    $display("Simulation FAILED");
    $finish;
  end

  always @(negedge clk) begin
    out_tready = steady || ($urandom_range(0, 99) >= 10);
  end

  task automatic send_pixel(input logic [14:0] hue, input logic [8:0] sat,
                            input logic [8:0] val);
    while (!steady && $urandom_range(0, 99) < 10) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {7'b0, val, sat, hue};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin
    logic [14:0] h;
    logic [8:0]  s, v;
    out_of_range = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // sector edges at full saturation and value
    send_pixel(15'd0,     9'd256, 9'd256);
    send_pixel(15'd3839,  9'd256, 9'd256);
    send_pixel(15'd3840,  9'd256, 9'd256);
    send_pixel(15'd7679,  9'd256, 9'd256);
    send_pixel(15'd7680,  9'd256, 9'd256);
    send_pixel(15'd11520, 9'd256, 9'd256);
    send_pixel(15'd15360, 9'd256, 9'd256);
    send_pixel(15'd19200, 9'd256, 9'd256);
    send_pixel(15'd23039, 9'd256, 9'd256);
    // hue past 360 degrees lands in the last sector
    send_pixel(15'd23040, 9'd200, 9'd240);
    send_pixel(15'd32767, 9'd256, 9'd256);
    // gray and black
    send_pixel(15'd1920,  9'd0,   9'd256);
    send_pixel(15'd9000,  9'd0,   9'd100);
    send_pixel(15'd5760,  9'd256, 9'd0);
    // saturation and value above 1.0 clamp
    send_pixel(15'd17000, 9'd511, 9'd511);
    send_pixel(15'd2000,  9'd257, 9'd300);
    send_pixel(15'd13440, 9'd128, 9'd384);
    // mid-sector blends
    send_pixel(15'd1920,  9'd128, 9'd200);
    send_pixel(15'd5760,  9'd100, 9'd50);
    send_pixel(15'd13440, 9'd256, 9'd1);
    send_pixel(15'd17280, 9'd1,   9'd256);
    send_pixel(15'd21120, 9'd200, 9'd180);

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      steady = (i >= 250 && i < 400);
      if ($urandom_range(0, 99) < 15) begin
        // whole field range, including out-of-range encodings
        h = 15'($urandom());
        s = 9'($urandom());
        v = 9'($urandom());
        out_of_range++;
      end else begin
        h = 15'($urandom_range(0, 23039));
        s = 9'($urandom_range(0, 256));
        v = 9'($urandom_range(0, 256));
      end
      send_pixel(h, s, v);
    end
    steady = 1'b0;
    in_tvalid = 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d pixels: sector edges, clamp and gray cases, then %0d random",
             checked, RANDOM_PIXELS);
    $display("(%0d random with unconstrained fields) under random stalls on both sides",
             out_of_range);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
